[rtl/conv3_pkg.sv]
// Shared types and constants of the 3x3 streaming convolution.
// Has no dependencies; it is imported by the top level.
package conv3_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PRODUCT_W = 32;
    localparam int SUM_W     = 36;
    localparam int RESULT_W  = 24;
    localparam int FRAC_W    = 12;
    localparam int TAPS      = 3;
    localparam int KROW_W    = TAPS * COEF_W;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [COEF_W-1:0]    coef_t;
    typedef logic signed [PRODUCT_W-1:0] product_t;
    typedef logic signed [SUM_W-1:0]     sum_t;

    // Unity coefficient in Q4.12.
    localparam coef_t COEF_ONE = 16'sh1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_ROW_0 = 3'd2,
        CFG_KERNEL_ROW_1 = 3'd3,
        CFG_KERNEL_ROW_2 = 3'd4
    } cfg_reg_t;

    // Which neighbours of the output pixel lie inside the image.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

endpackage

[rtl/conv3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module conv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/conv3x3_zero_padded_stream.sv]
// Top level of the streaming 3x3 convolution with zero padding.
// Depends on conv3_pkg and on conv3_ram for the two line stores.
//
// Channel   | Direction | Handshake                      | Content
// ----------+-----------+--------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata: sample; tuser: flush
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata: result; tlast: last_of_frame
// cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// The block takes one item per clock cycle unless the output stalls. An item that produces
// a result passes stage 0 and stage 1 into the output register: the line store read
// completes at the accepting edge together with stage 0, the nine 16x16 multipliers sit
// between stage 0 and stage 1, and the adder tree sits between stage 1 and the output
// register. Reset clears the counters, the window, the pipeline valid bits and all
// coefficients but the centre one, which it sets to one; the line stores are not cleared,
// as their contents only reach taps outside the image, which are masked to zero. A stall
// at the output fills the stages one by one; the input takes items while a stage is empty.
module conv3x3_zero_padded_stream
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Input stream.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample
    input  logic                    s_axis_tuser,   // [0] flush
    // Output stream.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [RESULT_W-1:0]     m_axis_tdata,   // [23:0] result
    output logic                    m_axis_tlast,   // last_of_frame
    // Configuration writes.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [KROW_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int IW = $clog2(MAX_WIDTH + 2);
    localparam int RESET_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RESET_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // ------------------------------------------------------------------
    // Configuration. The dimensions are held already clamped to range.
    // ------------------------------------------------------------------
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    coef_t         coef_reg [TAPS][TAPS];
    logic [WW-1:0] w_clamped;
    logic [HW-1:0] h_clamped;
    logic          cfg_write;
    logic          cfg_dim_write;

    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;
    assign cfg_dim_write = cfg_write &&
                           ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

    always_comb
    begin
        if (cfg_data[DIM_W-1:0] == '0)
        begin
            w_clamped = WW'(1);
        end
        else if (32'(cfg_data[DIM_W-1:0]) > MAX_WIDTH)
        begin
            w_clamped = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = WW'(cfg_data[DIM_W-1:0]);
        end

        if (cfg_data[DIM_W-1:0] == '0)
        begin
            h_clamped = HW'(1);
        end
        else if (32'(cfg_data[DIM_W-1:0]) > MAX_HEIGHT)
        begin
            h_clamped = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_clamped = HW'(cfg_data[DIM_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WW'(RESET_W);
            h_reg <= HW'(RESET_H);
            for (int r = 0; r < TAPS; r++)
            begin
                for (int e = 0; e < TAPS; e++)
                begin
                    coef_reg[r][e] <= ((r == 1) && (e == 1)) ? COEF_ONE : '0;
                end
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  w_reg <= w_clamped;
                CFG_IMAGE_HEIGHT: h_reg <= h_clamped;
                CFG_KERNEL_ROW_0:
                begin
                    for (int e = 0; e < TAPS; e++)
                    begin
                        coef_reg[0][e] <= cfg_data[COEF_W*e +: COEF_W];
                    end
                end
                CFG_KERNEL_ROW_1:
                begin
                    for (int e = 0; e < TAPS; e++)
                    begin
                        coef_reg[1][e] <= cfg_data[COEF_W*e +: COEF_W];
                    end
                end
                CFG_KERNEL_ROW_2:
                begin
                    for (int e = 0; e < TAPS; e++)
                    begin
                        coef_reg[2][e] <= cfg_data[COEF_W*e +: COEF_W];
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves when it is empty or when the
    // stage after it moves.
    // ------------------------------------------------------------------
    logic s0_v_reg;
    logic s1_v_reg;
    logic out_v_reg;
    logic en0;
    logic en1;
    logic en2;
    logic accept;
    logic advance0;

    assign en2      = !out_v_reg || m_axis_tready;
    assign en1      = !s1_v_reg || en2;
    assign en0      = !s0_v_reg || en1;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign advance0 = s0_v_reg && en1;

    assign s_axis_tready = en0;

    // ------------------------------------------------------------------
    // Position counters, changed only as an item is accepted or a dimension is written.
    // ------------------------------------------------------------------
    logic [AW-1:0] col_reg;
    logic [HW-1:0] row_reg;
    logic [IW-1:0] item_cnt_reg;

    logic [AW-1:0] cc_cur;
    logic [AW-1:0] c_out;
    logic [IW-1:0] w_plus1;
    logic          emit;
    logic          cc_wrap;
    logic          c_last;
    logic          r_last;
    logic          last;
    border_t       border;

    always_comb
    begin
        cc_cur  = (WW'(col_reg) >= w_reg) ? '0 : col_reg;
        w_plus1 = IW'(w_reg) + IW'(1);
        emit    = item_cnt_reg >= w_plus1;
        cc_wrap = (WW'(cc_cur) + WW'(1)) == w_reg;
        // The output pixel sits one column behind the input column.
        c_out   = (cc_cur == '0) ? AW'(w_reg - WW'(1)) : cc_cur - AW'(1);
        c_last  = (WW'(c_out) + WW'(1)) == w_reg;
        r_last  = (row_reg + HW'(1)) >= h_reg;
        last    = r_last && c_last;

        border.top    = row_reg != '0;
        border.bottom = !r_last;
        border.left   = c_out != '0;
        border.right  = !c_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            item_cnt_reg <= '0;
        end
        else if (cfg_dim_write)
        begin
            // A change of dimensions abandons the frame in progress.
            col_reg      <= '0;
            row_reg      <= '0;
            item_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (emit && last)
            begin
                col_reg      <= '0;
                row_reg      <= '0;
                item_cnt_reg <= '0;
            end
            else
            begin
                col_reg <= cc_wrap ? '0 : cc_cur + AW'(1);
                if (!emit)
                begin
                    item_cnt_reg <= item_cnt_reg + IW'(1);
                end
                if (emit && c_last)
                begin
                    row_reg <= row_reg + HW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accepted item, line store read in flight.
    // ------------------------------------------------------------------
    sample_t       x0_reg;
    logic [AW-1:0] cc0_reg;
    logic          emit0_reg;
    logic          last0_reg;
    border_t       border0_reg;

    logic          byp_reg;
    sample_t       byp_a_reg;
    sample_t       byp_b_reg;

    logic [SAMPLE_W-1:0] ram_a_q;
    logic [SAMPLE_W-1:0] ram_b_q;
    sample_t             a_cur;
    sample_t             b_cur;

    // With a width of one, or when a frame ends and the next one starts again at column
    // zero, the same entry is read and written in the same cycle; the values being written
    // are forwarded instead of the stale read.
    assign a_cur = byp_reg ? byp_a_reg : sample_t'(ram_a_q);
    assign b_cur = byp_reg ? byp_b_reg : sample_t'(ram_b_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                s0_v_reg <= s_axis_tvalid;
            end
            if (cfg_dim_write)
            begin
                byp_reg <= 1'b0;
            end
            else if (accept)
            begin
                byp_reg <= advance0 && (cc0_reg == cc_cur);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg      <= s_axis_tuser ? '0 : sample_t'(s_axis_tdata);
            cc0_reg     <= cc_cur;
            emit0_reg   <= emit;
            last0_reg   <= last;
            border0_reg <= border;
            byp_a_reg   <= x0_reg;
            byp_b_reg   <= a_cur;
        end
    end

    // Line store A holds the previous row, line store B the one before it.
    conv3_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk     (clk),
        .wr_en   (advance0),
        .wr_addr (cc0_reg),
        .wr_data (x0_reg),
        .rd_en   (accept),
        .rd_addr (cc_cur),
        .rd_data (ram_a_q)
    );

    conv3_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk     (clk),
        .wr_en   (advance0),
        .wr_addr (cc0_reg),
        .wr_data (a_cur),
        .rd_en   (accept),
        .rd_addr (cc_cur),
        .rd_data (ram_b_q)
    );

    // ------------------------------------------------------------------
    // Stage 1: window shift and the nine masked products.
    // ------------------------------------------------------------------
    sample_t  win_reg  [TAPS][TAPS];
    sample_t  win_next [TAPS][TAPS];
    product_t prod_next [TAPS*TAPS];
    product_t prod_reg  [TAPS*TAPS];
    logic     last1_reg;

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            win_next[j][0] = win_reg[j][1];
            win_next[j][1] = win_reg[j][2];
        end
        win_next[0][2] = b_cur;
        win_next[1][2] = a_cur;
        win_next[2][2] = x0_reg;
    end

    // Row j and column i of the window meet the kernel flipped in both axes;
    // taps outside the image contribute nothing.
    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                if (((j == 0) && !border0_reg.top) || ((j == 2) && !border0_reg.bottom) ||
                    ((i == 0) && !border0_reg.left) || ((i == 2) && !border0_reg.right))
                begin
                    prod_next[j*TAPS + i] = product_t'(0);
                end
                else
                begin
                    prod_next[j*TAPS + i] = coef_reg[TAPS-1-j][TAPS-1-i] * win_next[j][i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            for (int j = 0; j < TAPS; j++)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    win_reg[j][i] <= '0;
                end
            end
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= s0_v_reg && emit0_reg;
            end
            if (advance0)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance0)
        begin
            prod_reg  <= prod_next;
            last1_reg <= last0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: adder tree and arithmetic shift into the output register.
    // ------------------------------------------------------------------
    sum_t                sum;
    logic [RESULT_W-1:0] result_reg;
    logic                last_out_reg;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAPS*TAPS; k++)
        begin
            sum = sum + sum_t'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_v_reg)
        begin
            result_reg   <= sum[FRAC_W +: RESULT_W];
            last_out_reg <= last1_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = result_reg;
    assign m_axis_tlast  = last_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < w_reg)
        else $error("column counter has reached the image width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < h_reg)
        else $error("row counter has reached the image height");

    a_bypass_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> (cc0_reg == '0))
        else $error("line store forwarding used away from the first column");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && last) |=> (item_cnt_reg == '0) && (row_reg == '0))
        else $error("counters did not restart after the last pixel of a frame");

    a_bubble_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s0_v_reg |-> s_axis_tready)
        else $error("input stalled although the first stage is empty");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for conv3x3_zero_padded_stream, the 3x3 zero-padded convolution.
// Depends on conv3_pkg and the block's RTL; a scoreboard class predicts every output pixel.
`timescale 1ns / 100ps

module tb_top;
    import conv3_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    // Random phases stop once this many items have gone; the tall frame at the end adds
    // about a thousand more.
    localparam int ITEM_BUDGET   = 200;
    // The pipeline is three stages deep, so SETTLE_CYCLES quiet cycles are ample before a write.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 30;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic                last;
    } pixel_t;

    // Scoreboard: keeps its own copy of the line stores, the 3x3 window and the frame
    // counters, and turns each accepted input item into the pixel it should release, if any.
    class conv_scoreboard;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic [KROW_W-1:0] kernel[TAPS];
        sample_t           line_prev[MAX_W];   // row above the newest sample
        sample_t           line_prev2[MAX_W];  // two rows above
        sample_t           taps[TAPS][TAPS];   // [row: top..bottom][column: left..right]
        int unsigned       in_col;
        int unsigned       out_row;
        int unsigned       frame_items;
        pixel_t            expected_pixels[$];
        int                errors;

        function new();
            width_reg  = DIM_W'(MAX_W);
            height_reg = DIM_W'(MAX_H);
            kernel[0]  = '0;
            kernel[1]  = {COEF_W'(0), COEF_ONE, COEF_W'(0)};
            kernel[2]  = '0;
            foreach (line_prev[k])
            begin
                line_prev[k]  = '0;
                line_prev2[k] = '0;
            end
            foreach (taps[j, i])
                taps[j][i] = '0;
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            in_col      = 0;
            out_row     = 0;
            frame_items = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_W) ? MAX_W : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0)
                return 1;
            return (height_reg > MAX_H) ? MAX_H : height_reg;
        endfunction

        function int unsigned outstanding();
            return expected_pixels.size();
        endfunction

        // A change of either dimension abandons the frame in progress.
        function void note_config(cfg_reg_t idx, logic [KROW_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:
                begin
                    width_reg = value[DIM_W-1:0];
                    restart_frame();
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_reg = value[DIM_W-1:0];
                    restart_frame();
                end
                CFG_KERNEL_ROW_0: kernel[0] = value;
                CFG_KERNEL_ROW_1: kernel[1] = value;
                CFG_KERNEL_ROW_2: kernel[2] = value;
                default: ;
            endcase
        endfunction

        function void note_sample(sample_t value, bit flush);
            int unsigned w;
            int unsigned h;
            int unsigned cc;
            int unsigned c;
            int unsigned r;
            sample_t     x;
            sample_t     above;
            sample_t     above2;
            longint      acc;
            longint      shifted;
            pixel_t      pix;
            w = eff_width();
            h = eff_height();
            x = flush ? sample_t'(0) : value;
            cc = (in_col >= w) ? 0 : in_col;
            above  = line_prev[cc];
            above2 = line_prev2[cc];
            line_prev2[cc] = above;
            line_prev[cc]  = x;
            for (int j = 0; j < TAPS; j++)
            begin
                taps[j][0] = taps[j][1];
                taps[j][1] = taps[j][2];
            end
            taps[0][2] = above2;
            taps[1][2] = above;
            taps[2][2] = x;
            in_col = (cc + 1 == w) ? 0 : cc + 1;
            // The first w+1 items of a frame only fill the window.
            if (frame_items < w + 1)
            begin
                frame_items++;
                return;
            end
            frame_items++;
            c = (cc == 0) ? w - 1 : cc - 1;
            r = out_row;
            acc = 0;
            for (int j = 0; j < TAPS; j++)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    coef_t k;
                    k = coef_t'(kernel[2 - j][(2 - i) * COEF_W +: COEF_W]);
                    // Taps beyond the image border read as zero.
                    if (!((j == 0 && r == 0) || (j == 2 && r + 1 >= h) ||
                          (i == 0 && c == 0) || (i == 2 && c + 1 >= w)))
                        acc += longint'(k) * longint'(taps[j][i]);
                end
            end
            shifted    = acc >>> FRAC_W;
            pix.result = shifted[RESULT_W-1:0];
            pix.last   = (r + 1 >= h) && (c + 1 == w);
            expected_pixels.push_back(pix);
            if (pix.last)
                restart_frame();
            else if (c + 1 == w)
                out_row++;
        endfunction

        function void check_pixel(logic [RESULT_W-1:0] result, logic last);
            pixel_t exp_pix;
            if (expected_pixels.size() == 0)
            begin
                if (errors < REPORT_LIMIT)
                    $error("output pixel %0h arrived with no pixel expected", result);
                errors++;
                return;
            end
            exp_pix = expected_pixels.pop_front();
            if (result !== exp_pix.result)
            begin
                if (errors < REPORT_LIMIT)
                    $error("result: expected %0h, got %0h", exp_pix.result, result);
                errors++;
            end
            if (last !== exp_pix.last)
            begin
                if (errors < REPORT_LIMIT)
                    $error("last_of_frame: expected %0b, got %0b", exp_pix.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;   // [15:0] sample
    logic                s_axis_tuser;   // [0] flush
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [RESULT_W-1:0] m_axis_tdata;   // [23:0] result
    logic                m_axis_tlast;   // last_of_frame
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KROW_W-1:0]   cfg_data;

    conv_scoreboard sb = new();
    int unsigned    items_sent = 0;
    bit             calm_input = 1'b0;   // no gaps on the input side during this phase
    bit             realign = 1'b0;      // a frame was cut short, so rewrite a dimension

    conv3x3_zero_padded_stream #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 9);
        return $urandom_range(15, 30);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(16'h7FFF);
            1: return sample_t'(16'h8000);
            2: return sample_t'(0);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t random_coef();
        case ($urandom_range(0, 5))
            0: return coef_t'(16'h8000);
            1: return coef_t'(16'h7FFF);
            2: return COEF_ONE;
            3: return coef_t'(0);
            4: return coef_t'($urandom_range(0, 8191) - 4096);
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] random_kernel_row();
        return {random_coef(), random_coef(), random_coef()};
    endfunction

    // Zero, which clamps to one, or usually a small size.
    function automatic int unsigned pick_dim(int unsigned limit);
        case ($urandom_range(0, 15))
            0: return 0;
            default: return $urandom_range(1, limit);
        endcase
    endfunction

    // Dimension writes carry random junk above the 11-bit field.
    function automatic logic [KROW_W-1:0] dim_word(int unsigned d);
        logic [KROW_W-1:0] word;
        word = KROW_W'({$urandom, $urandom});
        word[DIM_W-1:0] = DIM_W'(d);
        return word;
    endfunction

    // Output side: runs of ready, broken by stalls; a long run gives a stall-free stretch.
    initial
    begin
        int unsigned run;
        m_axis_tready = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            @(negedge clk) m_axis_tready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            run = idle_len();
            if (run > 0)
            begin
                @(negedge clk) m_axis_tready <= 1'b0;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // Offers one item, after an optional gap, and returns at the edge that accepts it.
    task automatic send_item(sample_t value, bit flush);
        int unsigned gap;
        gap = calm_input ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= flush;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(value, flush);
        items_sent++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [KROW_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.note_config(idx, value);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Stops the input, waits for every expected pixel, then lets the pipeline run dry,
    // since items that release no pixel may still be inside it.
    task automatic settle();
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A frame is w*h pixels followed by w+1 drain items. A noisy frame slips flush items
    // in among the pixels and pixels in among the drain items; limit can cut it short.
    task automatic send_frame(int unsigned w, int unsigned h, bit noisy, int unsigned limit);
        for (int unsigned n = 0; n < limit; n++)
        begin
            if (n < w * h)
                send_item(random_sample(), noisy && ($urandom_range(0, 15) == 0));
            else if (noisy && ($urandom_range(0, 7) == 0))
                send_item(random_sample(), 1'b0);
            else
                send_item(random_sample(), 1'b1);
        end
    endtask

    task automatic run_random_phase();
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned full;
        bit          noisy;
        settle();
        calm_input = ($urandom_range(0, 3) == 0);
        if (realign || ($urandom_range(0, 1) == 1))
            write_reg(CFG_IMAGE_WIDTH, dim_word(pick_dim(10)));
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IMAGE_HEIGHT, dim_word(pick_dim(6)));
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_KERNEL_ROW_0, random_kernel_row());
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_KERNEL_ROW_1, random_kernel_row());
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_KERNEL_ROW_2, random_kernel_row());
        realign = 1'b0;
        w = sb.eff_width();
        h = sb.eff_height();
        full = w * h + w + 1;
        frames = $urandom_range(1, 3);
        noisy = ($urandom_range(0, 2) == 0);
        for (int unsigned f = 0; f < frames; f++)
        begin
            // Now and then the last frame is abandoned part way through.
            if (f == frames - 1 && $urandom_range(0, 7) == 0)
            begin
                send_frame(w, h, noisy, $urandom_range(1, full - 1));
                realign = 1'b1;
            end
            else
                send_frame(w, h, noisy, full);
        end
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_IMAGE_WIDTH;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // With the reset sizes nothing is released yet; the width write abandons the frame.
        send_item(sample_t'(16'h7FFF), 1'b0);
        send_item(sample_t'(16'h8000), 1'b0);
        send_item(sample_t'(16'h1234), 1'b1);
        send_item(sample_t'(0), 1'b0);
        settle();

        // A 3x3 frame with extreme coefficients and mostly full-scale samples of both signs, a flush
        // in the middle of the frame and a pixel among the drain items.
        write_reg(CFG_IMAGE_WIDTH, dim_word(3));
        write_reg(CFG_IMAGE_HEIGHT, dim_word(3));
        write_reg(CFG_KERNEL_ROW_0, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_reg(CFG_KERNEL_ROW_1, {16'h8000, 16'h1000, 16'h7FFF});
        write_reg(CFG_KERNEL_ROW_2, {16'h8000, 16'hFFFF, 16'h0001});
        send_item(sample_t'(16'h7FFF), 1'b0);
        send_item(sample_t'(16'h8000), 1'b0);
        send_item(sample_t'(16'h7FFF), 1'b0);
        send_item(sample_t'(16'h8000), 1'b0);
        send_item(sample_t'(16'h7FFF), 1'b1);
        send_item(sample_t'(16'h7FFF), 1'b0);
        send_item(sample_t'(16'h8000), 1'b0);
        send_item(sample_t'(16'h7FFF), 1'b0);
        send_item(sample_t'(16'hFFFF), 1'b0);
        send_item(sample_t'(0), 1'b1);
        send_item(sample_t'(16'h5555), 1'b0);
        send_item(sample_t'(16'hAAAA), 1'b1);
        send_item(sample_t'(0), 1'b1);
        settle();

        // Zero sizes clamp to a single pixel per frame.
        write_reg(CFG_IMAGE_WIDTH, dim_word(0));
        write_reg(CFG_IMAGE_HEIGHT, dim_word(0));
        send_item(sample_t'(16'h8000), 1'b0);
        send_item(sample_t'(0), 1'b1);
        send_item(sample_t'(0), 1'b1);

        while (items_sent < ITEM_BUDGET)
            run_random_phase();

        // The tallest column, reached through clamping of an oversized height.
        settle();
        calm_input = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, dim_word(1));
        write_reg(CFG_IMAGE_HEIGHT, dim_word($urandom_range(MAX_H + 1, 2047)));
        write_reg(CFG_KERNEL_ROW_0, random_kernel_row());
        write_reg(CFG_KERNEL_ROW_1, random_kernel_row());
        write_reg(CFG_KERNEL_ROW_2, random_kernel_row());
        send_frame(1, MAX_H, 1'b1, MAX_H + 2);

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Several times the slowest correct run, with every gap and stall at its longest.
    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
